// ===== design/tdp_pkg.sv =====
// Package for the trial-division prime test.
// Holds the value width, derived widths, types and small constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

  // Width of the tested value (8 .. 32).
  localparam int VALUE_WIDTH = 24;

  // The divisor never exceeds sqrt(2^VALUE_WIDTH) + 2.
  localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 2;
  // The running square of the divisor.
  localparam int SQ_W  = 2 * DIV_W;
  // Counts the bits of the value shifted through the remainder unit.
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [DIV_W-1:0]       divisor_t;
  typedef logic [SQ_W-1:0]        square_t;
  typedef logic [CNT_W-1:0]       bitcnt_t;

  localparam value_t   SMALLEST_PRIME = value_t'(2);
  localparam divisor_t FIRST_DIV      = divisor_t'(3);
  localparam square_t  FIRST_SQ       = square_t'(3 * 3);
  localparam divisor_t DIV_STEP       = divisor_t'(2);
  localparam square_t  SQ_STEP_CONST  = square_t'(4);

  // Control into the remainder unit.
  typedef struct packed {
    logic start;
  } rem_ctl_t;

  // Status out of the remainder unit.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_sts_t;

endpackage

`default_nettype wire

// ===== design/tdp_in_if.sv =====
// Input channel interface: valid/ready handshake carrying one candidate word.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tdp_in_if;
  import tdp_pkg::*;

  logic   valid;
  logic   ready;
  value_t candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

`default_nettype wire

// ===== design/tdp_out_if.sv =====
// Result channel interface: valid/ready handshake carrying one prime flag word.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tdp_out_if;
  import tdp_pkg::*;

  logic valid;
  logic ready;
  logic prime_flag;

  modport source (output valid, output prime_flag, input ready);
  modport sink   (input valid, input prime_flag, output ready);
endinterface

`default_nettype wire

// ===== design/tdp_rem.sv =====
// Bit-serial remainder unit: restoring division, one dividend bit per cycle.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdp_rem (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire tdp_pkg::rem_ctl_t  ctl,
  input  wire tdp_pkg::value_t    dividend,
  input  wire tdp_pkg::divisor_t  divisor,
  output tdp_pkg::rem_sts_t       sts
);
  import tdp_pkg::*;

  logic               busy_r;
  logic               done_r;
  bitcnt_t            cnt_r;
  value_t             shf_r;
  logic [DIV_W:0]     rem_r;
  logic [DIV_W:0]     rem_sh;
  logic [DIV_W:0]     rem_nxt;

  // Bring in the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    rem_sh = {rem_r[DIV_W-1:0], shf_r[VALUE_WIDTH-1]};
    if (rem_sh >= {1'b0, divisor}) begin
      rem_nxt = rem_sh - {1'b0, divisor};
    end else begin
      rem_nxt = rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= bitcnt_t'(VALUE_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - bitcnt_t'(1);
        if (cnt_r == bitcnt_t'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      shf_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      shf_r <= {shf_r[VALUE_WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign sts.done = done_r;
  assign sts.zero = (rem_r == '0);

endmodule

`default_nettype wire

// ===== design/trial_division_prime_test.sv =====
// Top level of the trial-division prime test: sequencer, divisor and square
// registers, output register. Depends on tdp_pkg, tdp_in_if, tdp_out_if, tdp_rem.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one candidate word on in_ch and returns one prime_flag word
// on out_ch. Both channels use a valid/ready handshake; a word moves at a
// rising clock edge where valid and ready are both high.
// Values below two, and even values other than two, are decided in the cycle
// after acceptance. An odd value is divided by 3, 5, 7, ... while the divisor
// squared does not exceed it. The remainder unit works bit-serially, one value
// bit per cycle; the loop state launches it for each divisor and the divide
// state waits for it to report done. The number of divisors tried is about
// sqrt(value) / 2, so a large prime of 24 bits needs about 2048 divisors; a
// composite stops at its smallest odd factor.
// One candidate is worked on at a time: in_ch.ready is high only while the
// sequencer is idle. The finished result sits in an output register, so the
// next candidate can be accepted while the previous result still waits; if
// a second result finishes before the first is taken, the sequencer holds it.
// Reset is synchronous and active low; it empties the output register and
// returns the sequencer to idle. Nothing is carried from one candidate to the
// next.

module trial_division_prime_test (
  input  wire        clk,
  input  wire        rst_n,
  tdp_in_if.sink     in_ch,
  tdp_out_if.source  out_ch
);
  import tdp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0] state_r;
  value_t     v_r;        // candidate under test
  divisor_t   d_r;        // current odd divisor
  square_t    sq_r;       // d_r squared, kept up to date by adds
  logic       res_r;      // finished verdict waiting for the output register
  logic       out_valid_r;
  logic       flag_r;

  rem_ctl_t   rem_ctl;
  rem_sts_t   rem_sts;
  logic       in_take;
  logic       out_free;
  logic       sq_over;

  assign in_take  = in_ch.valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  // The loop ends once the square of the divisor passes the value.
  assign sq_over  = (sq_r > square_t'(v_r));

  assign rem_ctl.start = (state_r == S_LOOP) && !sq_over;

  tdp_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (v_r),
    .divisor  (d_r),
    .sts      (rem_sts)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            if (in_ch.candidate <= SMALLEST_PRIME || !in_ch.candidate[0]) begin
              state_r <= S_HOLD;
            end else begin
              state_r <= S_LOOP;
            end
          end
        end
        S_LOOP: begin
          if (sq_over) begin
            state_r <= S_HOLD;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sts.done) begin
            if (rem_sts.zero) begin
              state_r <= S_HOLD;
            end else begin
              state_r <= S_LOOP;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Working registers; no reset needed, they are loaded on acceptance.
  always_ff @(posedge clk) begin
    if (in_take) begin
      v_r  <= in_ch.candidate;
      d_r  <= FIRST_DIV;
      sq_r <= FIRST_SQ;
      // Two is the only prime decided here; other small or even values are not.
      res_r <= (in_ch.candidate == SMALLEST_PRIME);
    end else if (state_r == S_LOOP && sq_over) begin
      res_r <= 1'b1;
    end else if (state_r == S_DIV && rem_sts.done) begin
      if (rem_sts.zero) begin
        res_r <= 1'b0;
      end else begin
        // (d + 2)^2 = d^2 + 4d + 4
        d_r  <= d_r + DIV_STEP;
        sq_r <= sq_r + (square_t'(d_r) << 2) + SQ_STEP_CONST;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_HOLD && out_free) begin
      flag_r <= res_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.prime_flag = flag_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for trial_division_prime_test: directed and random candidate words,
// random idling on both channels and a long result hold-off.
// Depends on tdp_pkg, tdp_in_if, tdp_out_if and the block itself.
`timescale 1ns / 1ps

module tb;
  import tdp_pkg::*;

  // Cycles the result side holds ready low in the pressure phase. That is long
  // enough for the output register and the sequencer to fill with results, so
  // the block has to stall its input.
  localparam int HOLD_CYCLES  = 400;
  // Cycles to wait after the last expected word. No stray result may arrive
  // in that time.
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_WORDS = 75;

  // Keeps the expected prime flags in acceptance order and checks each
  // result word against the oldest one.
  class primality_board;
    bit flags_due[$];
    int errors;
    int checked;
    int primes_seen;

    // Trial division in 64 bits, so the running square cannot overflow.
    function bit trial_divide(value_t cand);
      logic [63:0] n;
      logic [63:0] d;
      n = 64'(cand);
      if (n < 64'd2) return 1'b0;
      if (n == 64'd2) return 1'b1;
      if (!n[0]) return 1'b0;
      for (d = 64'd3; d * d <= n; d += 64'd2) begin
        if (n % d == 64'd0) return 1'b0;
      end
      return 1'b1;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void note_candidate(value_t cand);
      bit flag;
      flag = trial_divide(cand);
      flags_due.push_back(flag);
      if (flag) primes_seen++;
    endfunction

    task check_flag(logic got);
      bit want;
      if (flags_due.size() == 0) begin
        report_mismatch($sformatf("result word %b with no candidate waiting", got));
      end else begin
        want = flags_due.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("prime_flag %b, expected %b (result %0d)",
                                    got, want, checked));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  tdp_in_if  in_ch();
  tdp_out_if out_ch();

  trial_division_prime_test dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  primality_board board;

  // When set, neither side idles; this gives a long stretch at full rate.
  bit quiet;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit hold_pending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global limit. Only the two large directed candidates and the eight
  // full-width random ones can need the full 2048 divisors.
  initial begin
    #40_000_000;
    $display("[%0t] timeout with %0d result words outstanding",
             $realtime, board.flags_due.size());
    $display("simulation failed");
    $finish;
  end

  // Result side: takes result words, checks them and drives ready. A word
  // moves at an edge where valid and ready were both high, so the check reads
  // the values from before the edge. The hold-off is counted here, apart from
  // the sender, so the sender can keep offering words while it runs.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) board.check_flag(out_ch.prime_flag);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 10);
      end
    end
  end

  // Offers one candidate word and returns once it has been accepted. Idle
  // cycles come before the offer at random. Valid gets only one assignment in
  // a time step, so back-to-back words keep it high without a glitch.
  task automatic offer_word(value_t cand);
    while (!quiet && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.candidate <= cand;
    do @(posedge clk); while (!in_ch.ready);
    board.note_candidate(cand);
  endtask

  initial begin : stimulus
    value_t directed[$];
    value_t cand;
    int     pick;
    board = new();
    quiet = 1'b0;
    hold_pending = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.candidate <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: zero and one, the smallest prime, small odd primes and
    // squares of primes (the divisor squared equals the value), even values,
    // the full-width all-ones word, the largest 24-bit prime and the square of
    // the largest 12-bit prime, which walks the divisor up to its limit.
    directed = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd9, 24'd25,
                 24'd49, 24'd97, 24'd121, 24'd4097, 24'd65521, 24'd65535,
                 24'd8388608, 24'd8388609, 24'd16777214, 24'd16777215,
                 24'd16777213, 24'd16752649};
    foreach (directed[i]) offer_word(directed[i]);

    // Let the last large candidate finish first, so that the hold-off meets
    // an idle block and the quick words behind it pile up.
    in_ch.valid <= 1'b0;
    while (board.flags_due.size() != 0) @(posedge clk);

    // Pressure: the result side holds off while quick words keep coming, so
    // the output register fills, the sequencer holds a second result and the
    // input stalls until the hold-off ends.
    hold_pending = 1'b1;
    directed = '{24'd7, 24'd6, 24'd1, 24'd33, 24'd13};
    foreach (directed[i]) offer_word(directed[i]);

    // Random words. Most are small, since a large prime takes long to test;
    // every tenth uses the full width so that each bit takes both values.
    // One stretch runs with no idling on either side.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet = (i >= 30 && i < 55);
      pick = $urandom_range(99);
      if (i % 10 == 0)  cand = value_t'($urandom());
      else if (pick < 60) cand = value_t'($urandom_range(4095));
      else if (pick < 85) cand = value_t'($urandom_range(65535));
      else                cand = value_t'($urandom_range(40));
      offer_word(cand);
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    // Wait for every expected word, then a little longer for strays.
    while (board.flags_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words, %0d of them prime, from zero up to full width,",
             board.checked, board.primes_seen);
    $display("with random idling, a full-rate stretch and a %0d-cycle result hold-off.",
             HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
